// ===== hdl/glev_pkg.sv =====
// glev_pkg: shared types, constants and saturation helpers for the
// gaussian likelihood evaluator. No dependencies.
package glev_pkg;

    localparam int MAX_DIMS    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int QF_W        = 48;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [1:0] REG_DIMS  = 2'd0;
    localparam logic [1:0] REG_SCALE = 2'd1;
    localparam logic [1:0] REG_MINP  = 2'd2;

    localparam logic [1:0] MODE_MEAN   = 2'd0;
    localparam logic [1:0] MODE_COV    = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    localparam logic [16:0] INV_2LN2_Q16 = 17'd47274;
    localparam logic [15:0] LN2_Q16      = 16'd45426;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [2:0]  HORNER_TOP   = 3'd6;

    typedef enum logic [1:0] {
        KIND_MEAN,
        KIND_COV,
        KIND_SAMPLE
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                    last;
    } item_t;

    typedef enum logic [1:0] {
        PH_DIAG,
        PH_UPPER,
        PH_LOWER
    } phase_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIFF,
        BK_RD,
        BK_MUL1,
        BK_MUL2,
        BK_ACC,
        BK_FIN,
        BK_EXP,
        BK_OUT
    } bk_state_t;

    typedef enum logic [3:0] {
        EX_IDLE,
        EX_T,
        EX_R,
        EX_H1,
        EX_H2,
        EX_H3,
        EX_MANT,
        EX_SH,
        EX_DONE
    } ex_state_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [47:0] x);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = -48'sh0000_8000_0000;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return -32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat_s48(input logic signed [48:0] x);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sh0_7FFF_FFFF_FFFF;
        lo = -49'sh0_8000_0000_0000;
        if (x > hi) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (x < lo) begin
            return -48'sh8000_0000_0000;
        end
        return x[47:0];
    endfunction

    // floor(2^32 / k) for the Horner divisors
    function automatic logic [32:0] recip(input logic [2:0] k);
        logic [32:0] m;
        m = '0;
        case (k)
            3'd1:    m = 33'h1_0000_0000;
            3'd2:    m = 33'h0_8000_0000;
            3'd3:    m = 33'd1431655765;
            3'd4:    m = 33'h0_4000_0000;
            3'd5:    m = 33'd858993459;
            3'd6:    m = 33'd715827882;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/glev_front.sv =====
// glev_front: accepts input transfers, classifies the mode, drops unknown modes and
// queues the other items for the back end. Depends on glev_pkg.
module glev_front import glev_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [IDX_W-1:0]              s_row,
    input  logic [IDX_W-1:0]              s_col,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  logic                          s_last,
    output logic                          q_valid,
    output item_t                         q_item,
    input  logic                          q_pop
);

    item_t      fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    item_t      in_item;
    logic       keep;
    logic       push, pop;

    always_comb begin
        in_item.row   = s_row;
        in_item.col   = s_col;
        in_item.value = s_value;
        in_item.last  = s_last;
        in_item.kind  = KIND_SAMPLE;
        keep          = 1'b1;
        unique case (s_mode)
            MODE_MEAN:   in_item.kind = KIND_MEAN;
            MODE_COV:    in_item.kind = KIND_COV;
            MODE_SAMPLE: in_item.kind = KIND_SAMPLE;
            default:     keep = 1'b0;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready && keep;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hdl/glev_exp.sv =====
// glev_exp: probability unit, scale*exp(-q/2) with range reduction,
// Horner series and floor. Depends on glev_pkg.
module glev_exp import glev_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [QF_W-1:0] quad,
    input  logic [31:0]            scale_factor,
    input  logic [31:0]            prob_floor,
    output logic                   done,
    output logic [31:0]            probability
);

    ex_state_t state_reg, state_next;

    logic signed [QF_W-1:0] q_reg;
    logic signed [63:0]     t_reg;
    logic signed [31:0]     n_reg;
    logic [29:0]            r30_reg;
    logic [30:0]            w_reg;
    logic [2:0]             k_reg;
    logic [59:0]            p_reg;
    logic [29:0]            x_reg;
    logic [62:0]            xm_reg;
    logic [62:0]            mant_reg;
    logic [31:0]            prob_reg;

    logic [31:0]        rprod;
    logic [29:0]        x_c;
    logic [30:0]        q0, qk, rem, qd;
    logic signed [33:0] s;
    logic [33:0]        ls;
    logic [94:0]        wide;
    logic [62:0]        rsh;
    logic [31:0]        res;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            EX_IDLE: if (start) state_next = EX_T;
            EX_T:    state_next = EX_R;
            EX_R:    state_next = EX_H1;
            EX_H1:   state_next = EX_H2;
            EX_H2:   state_next = EX_H3;
            EX_H3:   state_next = (k_reg == 3'd1) ? EX_MANT : EX_H1;
            EX_MANT: state_next = EX_SH;
            EX_SH:   state_next = EX_DONE;
            EX_DONE: state_next = EX_IDLE;
            default: state_next = EX_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == EX_DONE);
    end

    assign probability = prob_reg;

    always_comb begin
        rprod = 32'(t_reg[31:16]) * 32'(LN2_Q16);
        x_c   = p_reg[59:30];
        q0    = xm_reg[62:32];
        qk    = 31'(34'(q0) * 34'(k_reg));
        rem   = {1'b0, x_reg} - qk;
        qd    = (rem >= 31'(k_reg)) ? q0 + 31'd1 : q0;
    end

    always_comb begin
        s    = 34'sd30 + 34'(n_reg);
        ls   = 34'(-s);
        rsh  = mant_reg >> s[5:0];
        wide = 95'(mant_reg) << ls[5:0];
        if (s >= 34'sd64) begin
            res = '0;
        end else if (s >= 34'sd0) begin
            res = (rsh > 63'hFFFF_FFFF) ? 32'hFFFF_FFFF : rsh[31:0];
        end else if (mant_reg == '0) begin
            res = '0;
        end else if (ls > 34'd32) begin
            res = 32'hFFFF_FFFF;
        end else begin
            res = (wide > 95'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end
        if (res < prob_floor) begin
            res = prob_floor;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            EX_IDLE: q_reg <= quad;
            EX_T:    t_reg <= 64'(q_reg) * 64'($signed({1'b0, INV_2LN2_Q16}));
            EX_R: begin
                r30_reg <= rprod[31:2];
                n_reg   <= t_reg[63:32];
                w_reg   <= ONE_Q30;
                k_reg   <= HORNER_TOP;
            end
            EX_H1:   p_reg <= 60'(r30_reg) * 60'(w_reg);
            EX_H2: begin
                x_reg  <= x_c;
                xm_reg <= 63'(x_c) * 63'(recip(k_reg));
            end
            EX_H3: begin
                w_reg <= ONE_Q30 - qd;
                k_reg <= k_reg - 3'd1;
            end
            EX_MANT: mant_reg <= 63'(scale_factor) * 63'(w_reg);
            EX_SH:   prob_reg <= res;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EX_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/glev_back.sv =====
// glev_back: executes queued items: store writes, quadratic-form
// accumulation, result formation. Depends on glev_pkg and glev_exp.
module glev_back import glev_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  item_t                  q_item,
    output logic                   q_pop,
    input  logic [CNT_W-1:0]       dimensions,
    input  logic [31:0]            scale_factor,
    input  logic [31:0]            prob_floor,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_probability,
    output logic signed [QF_W-1:0] m_quad_form,
    output logic                   m_count_error
);

    bk_state_t state_reg, state_next;

    logic signed [VALUE_WIDTH-1:0] mean_reg [MAX_DIMS];
    logic signed [VALUE_WIDTH-1:0] diff_reg [MAX_DIMS];
    logic signed [VALUE_WIDTH-1:0] cov_mem  [MAX_DIMS*MAX_DIMS];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;

    logic signed [VALUE_WIDTH-1:0] val_reg, d_reg;
    logic                          last_reg, err_reg;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [QF_W-1:0]        acc_reg;
    logic [IDX_W-1:0]              j_reg;
    phase_t                        ph_reg;
    logic signed [63:0]            p1_reg, p2_reg;

    logic                          m_valid_reg;
    logic [31:0]                   prob_out_reg;
    logic signed [QF_W-1:0]        qf_out_reg;
    logic                          err_out_reg;

    logic [IDX_W-1:0]              k;
    logic [2*IDX_W-1:0]            rd_addr;
    logic signed [VALUE_WIDTH-1:0] a_op, b_op, h, d_c;
    logic signed [32:0]            dsum;
    logic                          in_range, more, mismatch, out_free;
    logic                          exp_start, exp_done, ld_out;
    logic [31:0]                   exp_prob;

    assign k        = cnt_reg[IDX_W-1:0];
    assign in_range = (cnt_reg < dimensions) && (cnt_reg < CNT_W'(MAX_DIMS));
    assign cnt_next = (cnt_reg == CNT_MAX) ? CNT_MAX : cnt_reg + 5'd1;
    assign mismatch = !((cnt_next == dimensions) && (dimensions <= CNT_W'(MAX_DIMS)));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        rd_addr = {k, k};
        a_op    = d_reg;
        b_op    = d_reg;
        more    = 1'b0;
        unique case (ph_reg)
            PH_DIAG: begin
                more = (k != '0);
            end
            PH_UPPER: begin
                rd_addr = {j_reg, k};
                a_op    = diff_reg[j_reg];
                more    = 1'b1;
            end
            PH_LOWER: begin
                rd_addr = {k, j_reg};
                b_op    = diff_reg[j_reg];
                more    = ((5'(j_reg) + 5'd1) < 5'(k));
            end
            default: ;
        endcase
    end

    always_comb begin
        dsum = 33'(val_reg) - 33'(mean_reg[k]);
        d_c  = sat_s32(48'(dsum));
        h    = sat_s32($signed(p1_reg[63:16]));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && q_item.kind == KIND_SAMPLE) begin
                    state_next = in_range ? BK_DIFF : BK_FIN;
                end
            end
            BK_DIFF: state_next = BK_RD;
            BK_RD:   state_next = BK_MUL1;
            BK_MUL1: state_next = BK_MUL2;
            BK_MUL2: state_next = BK_ACC;
            BK_ACC:  state_next = more ? BK_RD : BK_FIN;
            BK_FIN: begin
                if (!last_reg) begin
                    state_next = BK_IDLE;
                end else begin
                    state_next = mismatch ? BK_OUT : BK_EXP;
                end
            end
            BK_EXP:  if (exp_done) state_next = BK_OUT;
            BK_OUT:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = (state_reg == BK_IDLE);
        exp_start = (state_reg == BK_FIN) && last_reg && !mismatch;
        ld_out    = (state_reg == BK_OUT) && out_free;
    end

    // store writes and sample capture happen at the queue pop
    always_ff @(posedge aclk) begin
        if (q_pop && q_valid) begin
            unique case (q_item.kind)
                KIND_MEAN: mean_reg[q_item.row] <= q_item.value;
                KIND_COV:  cov_mem[{q_item.row, q_item.col}] <= q_item.value;
                KIND_SAMPLE: begin
                    val_reg  <= q_item.value;
                    last_reg <= q_item.last;
                end
                default: ;
            endcase
        end
        rd_data_reg <= cov_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_DIFF) begin
            diff_reg[k] <= d_c;
            d_reg       <= d_c;
        end
        if (state_reg == BK_MUL1) begin
            p1_reg <= 64'(a_op) * 64'(rd_data_reg);
        end
        if (state_reg == BK_MUL2) begin
            p2_reg <= 64'(h) * 64'(b_op);
        end
        if (state_reg == BK_FIN) begin
            err_reg <= mismatch;
        end
        if (ld_out) begin
            prob_out_reg <= err_reg ? '0 : exp_prob;
            qf_out_reg   <= err_reg ? '0 : acc_reg;
            err_out_reg  <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            j_reg       <= '0;
            ph_reg      <= PH_DIAG;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_DIFF) begin
                ph_reg <= PH_DIAG;
                j_reg  <= '0;
            end
            if (state_reg == BK_ACC) begin
                acc_reg <= sat_s48(49'(acc_reg) + 49'($signed(p2_reg[63:16])));
                unique case (ph_reg)
                    PH_DIAG:  ph_reg <= PH_UPPER;
                    PH_UPPER: ph_reg <= PH_LOWER;
                    PH_LOWER: begin
                        ph_reg <= PH_UPPER;
                        j_reg  <= j_reg + 4'd1;
                    end
                    default:  ph_reg <= PH_DIAG;
                endcase
            end
            if (state_reg == BK_FIN) begin
                cnt_reg <= cnt_next;
            end
            if (ld_out) begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            if (ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_probability = prob_out_reg;
    assign m_quad_form   = qf_out_reg;
    assign m_count_error = err_out_reg;

    glev_exp u_exp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (exp_start),
        .quad         (acc_reg),
        .scale_factor (scale_factor),
        .prob_floor   (prob_floor),
        .done         (exp_done),
        .probability  (exp_prob)
    );

endmodule

// ===== hdl/gaussian_likelihood_eval.sv =====
// gaussian_likelihood_eval: multivariate normal density evaluator. Store loads are
// written as the queue pops them, one per cycle while the back end is idle; sample
// element k runs DIFF, then RD, MUL1, MUL2, ACC for each of 2k+1 terms in turn,
// then FIN; the last one then passes the exp unit (not on a count error) and the
// output load. A 2-entry queue keeps the input side accepting while the back end
// works. Synchronous active-low reset clears control state, presets config regs.
module gaussian_likelihood_eval import glev_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [IDX_W-1:0]              s_row,
    input  logic [IDX_W-1:0]              s_col,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_probability,
    output logic signed [QF_W-1:0]        m_quad_form,
    output logic                          m_count_error
);

    logic [CNT_W-1:0] dims_reg;
    logic [31:0]      scale_reg;
    logic [31:0]      minp_reg;
    logic             wr_en;
    logic             q_valid, q_pop;
    item_t            q_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg  <= 5'd1;
            scale_reg <= 32'd65536;
            minp_reg  <= 32'd1;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_DIMS:  dims_reg  <= pwdata[CNT_W-1:0];
                REG_SCALE: scale_reg <= pwdata;
                REG_MINP:  minp_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DIMS:  prdata = DATA_W'(dims_reg);
            REG_SCALE: prdata = scale_reg;
            REG_MINP:  prdata = minp_reg;
            default:   prdata = '0;
        endcase
    end

    glev_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .s_row   (s_row),
        .s_col   (s_col),
        .s_value (s_value),
        .s_last  (s_last),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    glev_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .dimensions    (dims_reg),
        .scale_factor  (scale_reg),
        .prob_floor    (minp_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_probability (m_probability),
        .m_quad_form   (m_quad_form),
        .m_count_error (m_count_error)
    );

endmodule

// ===== sim/gaussian_likelihood_eval_tb.sv =====
// gaussian_likelihood_eval_tb: self-checking bench for the Gaussian density evaluator.
// It keeps its own fixed-point model of the stores, the quadratic form and the exp,
// and it drives random idling and backpressure. Depends on glev_pkg and the block.
module gaussian_likelihood_eval_tb;
    import glev_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         DRAIN_CYCLES = 400;
    localparam longint     V_MAX = 64'sd2147483647;
    localparam longint     V_MIN = -64'sd2147483648;
    localparam longint     Q_MAX = (64'sd1 <<< 47) - 1;
    localparam longint     Q_MIN = -(64'sd1 <<< 47);
    localparam longint unsigned U32_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic [31:0]     probability;
        logic [QF_W-1:0] quad_form;
        logic            count_error;
    } density_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ADDR_W-1:0]             paddr = '0;
    logic [DATA_W-1:0]             pwdata = '0;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_mode = '0;
    logic [IDX_W-1:0]              s_row = '0;
    logic [IDX_W-1:0]              s_col = '0;
    logic signed [VALUE_WIDTH-1:0] s_value = '0;
    logic                          s_last = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [31:0]                   m_probability;
    logic signed [QF_W-1:0]        m_quad_form;
    logic                          m_count_error;

    // model state
    longint          mean_mem [MAX_DIMS];
    longint          icov_mem [MAX_DIMS*MAX_DIMS];
    longint          diff_mem [MAX_DIMS];
    longint          qf_acc;
    int              elem_cnt;
    int unsigned     dims_reg;
    longint unsigned scale_reg;
    longint unsigned minp_reg;

    density_result_t pending_densities[$];
    int              mismatches = 0;
    int              cycles = 0;
    int              hold_cnt = 0;
    bit              no_idle = 1'b0;
    int              items_sent = 0;

    gaussian_likelihood_eval dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic longint sat_val(longint x);
        return x < V_MIN ? V_MIN : (x > V_MAX ? V_MAX : x);
    endfunction

    function automatic longint qf_term(longint a, longint m, longint b);
        longint h;
        h = sat_val((a * m) >>> 16);
        return (h * b) >>> 16;
    endfunction

    function automatic void acc_term(longint x);
        longint s;
        s = qf_acc + x;
        qf_acc = s < Q_MIN ? Q_MIN : (s > Q_MAX ? Q_MAX : s);
    endfunction

    function automatic logic [31:0] gauss_density(longint q);
        longint          t, n, s, ls;
        longint unsigned f16, r30, w, mant, res;
        t = q * 64'sd47274;
        n = t >>> 32;
        f16 = {48'b0, t[31:16]};
        r30 = (f16 * 64'd45426) >> 2;
        w = 64'd1 << 30;
        for (int k = 6; k >= 1; k--) begin
            w = (64'd1 << 30) - ((r30 * w) >> 30) / longint'(k);
        end
        mant = scale_reg * w;
        s = 30 + n;
        if (s >= 64) begin
            res = 0;
        end else if (s >= 0) begin
            res = mant >> s;
            if (res > U32_MAX) res = U32_MAX;
        end else begin
            ls = -s;
            if (mant == 0) res = 0;
            else if (ls > 32 || mant > (U32_MAX >> ls)) res = U32_MAX;
            else res = mant << ls;
        end
        if (res < minp_reg) res = minp_reg;
        return res[31:0];
    endfunction

    // Updates the model for one accepted item; queues a result on a closing element.
    function automatic void predict_item(logic [1:0] mode, logic [3:0] row, logic [3:0] col,
                                         logic signed [31:0] value, logic last);
        longint          v, d;
        int              k;
        density_result_t r;
        v = longint'(value);
        if (mode == MODE_MEAN) begin
            mean_mem[row] = v;
        end else if (mode == MODE_COV) begin
            icov_mem[row*MAX_DIMS + col] = v;
        end else if (mode == MODE_SAMPLE) begin
            k = elem_cnt;
            if (k < dims_reg && k < MAX_DIMS) begin
                d = sat_val(v - mean_mem[k]);
                diff_mem[k] = d;
                acc_term(qf_term(d, icov_mem[k*MAX_DIMS + k], d));
                for (int j = 0; j < k; j++) begin
                    acc_term(qf_term(diff_mem[j], icov_mem[j*MAX_DIMS + k], d));
                    acc_term(qf_term(d, icov_mem[k*MAX_DIMS + j], diff_mem[j]));
                end
            end
            if (elem_cnt < 31) elem_cnt++;
            if (last) begin
                if (elem_cnt == dims_reg && dims_reg <= MAX_DIMS) begin
                    r.probability = gauss_density(qf_acc);
                    r.quad_form = qf_acc[47:0];
                    r.count_error = 1'b0;
                end else begin
                    r.probability = '0;
                    r.quad_form = '0;
                    r.count_error = 1'b1;
                end
                pending_densities.push_back(r);
                qf_acc = 0;
                elem_cnt = 0;
            end
        end
    endfunction

    // Result side: check each transfer, then pick m_ready for the next edge.
    always @(posedge aclk) begin
        density_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_densities.size() == 0) begin
                report_mismatch("unexpected result", {32'b0, m_probability}, '0);
            end else begin
                want = pending_densities.pop_front();
                if (m_probability !== want.probability)
                    report_mismatch("probability", 64'(m_probability),
                                    64'(want.probability));
                if (m_quad_form !== want.quad_form)
                    report_mismatch("quad_form", 64'(m_quad_form), 64'(want.quad_form));
                if (m_count_error !== want.count_error)
                    report_mismatch("count_error", 64'(m_count_error),
                                    64'(want.count_error));
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    // Called at an edge; returns at the edge of the transfer with s_valid still high.
    task automatic send_item(logic [1:0] mode, logic [3:0] row, logic [3:0] col,
                             logic signed [31:0] value, logic last);
        int gap;
        if (!no_idle && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_row <= row;
        s_col <= col;
        s_value <= value;
        s_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(mode, row, col, value, last);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_densities.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DIMS:  dims_reg = data[4:0];
            REG_SCALE: scale_reg = data;
            REG_MINP:  minp_reg = data;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_sample();
        if ($urandom_range(9) == 0) return $urandom;
        return $signed($urandom_range(262143)) - 32'sd131072;
    endfunction

    function automatic logic signed [31:0] rand_cov();
        if ($urandom_range(19) == 0) return $urandom;
        return $signed($urandom_range(32767)) - 32'sd16384;
    endfunction

    task automatic send_vector(int len);
        for (int i = 0; i < len; i++)
            send_item(MODE_SAMPLE, 4'($urandom), 4'($urandom), rand_sample(), i == len - 1);
    endtask

    task automatic test_load_stores();
        for (int i = 0; i < MAX_DIMS; i++)
            send_item(MODE_MEAN, 4'(i), 4'($urandom),
                      $signed($urandom_range(131071)) - 32'sd65536, 1'($urandom));
        for (int i = 0; i < MAX_DIMS*MAX_DIMS; i++)
            send_item(MODE_COV, 4'(i / MAX_DIMS), 4'(i % MAX_DIMS), rand_cov(),
                      1'($urandom));
    endtask

    task automatic test_directed();
        cfg_write(REG_DIMS, 1);
        send_item(MODE_SAMPLE, 4'hF, 4'hF, 32'sh7FFF_FFFF, 1'b1);
        send_item(MODE_SAMPLE, 4'h0, 4'h0, 32'sh8000_0000, 1'b1);
        send_item(MODE_SAMPLE, 4'h0, 4'h0, 32'sh0, 1'b1);
        send_item(MODE_NONE, 4'hF, 4'hF, 32'shFFFF_FFFF, 1'b1);
        // count mismatch, then surplus elements past the dimension
        send_vector(2);
        cfg_write(REG_DIMS, 2);
        send_vector(1);
        send_vector(5);
        send_vector(2);
        // dimension zero and above the store depth
        cfg_write(REG_DIMS, 0);
        send_vector(1);
        cfg_write(REG_DIMS, 17);
        send_vector(17);
        cfg_write(REG_DIMS, 31);
        send_vector(3);
    endtask

    task automatic test_saturation();
        cfg_write(REG_DIMS, MAX_DIMS);
        cfg_write(REG_SCALE, 32'hFFFF_FFFF);
        cfg_write(REG_MINP, 32'h0);
        send_item(MODE_MEAN, 4'd0, 4'd0, 32'sh8000_0000, 1'b0);
        send_item(MODE_COV, 4'd0, 4'd0, 32'sh7FFF_FFFF, 1'b0);
        send_item(MODE_COV, 4'd1, 4'd1, 32'sh7FFF_FFFF, 1'b0);
        for (int i = 0; i < MAX_DIMS; i++)
            send_item(MODE_SAMPLE, 4'(i), 4'd0, 32'sh7FFF_FFFF, i == MAX_DIMS - 1);
        // negative form drives the exp shift far left
        send_item(MODE_COV, 4'd0, 4'd0, 32'sh8000_0000, 1'b0);
        cfg_write(REG_DIMS, 1);
        send_item(MODE_SAMPLE, 4'd0, 4'd0, 32'sh7FFF_FFFF, 1'b1);
        send_item(MODE_MEAN, 4'd0, 4'd0, 32'sh0, 1'b0);
        send_item(MODE_COV, 4'd0, 4'd0, 32'sh0001_0000, 1'b0);
        send_item(MODE_COV, 4'd1, 4'd1, 32'sh0000_4000, 1'b0);
        cfg_write(REG_MINP, 32'hFFFF_FFFF);
        send_vector(1);
        cfg_write(REG_SCALE, 32'h0);
        cfg_write(REG_MINP, 32'h1);
        send_vector(1);
        cfg_write(REG_SCALE, 32'h0001_0000);
    endtask

    task automatic test_backpressure();
        cfg_write(REG_DIMS, 2);
        no_idle = 1'b1;
        hold_cnt = 800;
        repeat (8) send_vector(2);
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int          dims, len, pick;
        logic [31:0] sc, mp;
        while (items_sent < 600) begin
            pick = $urandom_range(19);
            dims = pick < 12 ? $urandom_range(1, 4) : (pick < 16 ? $urandom_range(5, 16) :
                   (pick < 18 ? 16 : $urandom_range(0, 31)));
            cfg_write(REG_DIMS, dims);
            pick = $urandom_range(9);
            sc = pick < 5 ? $urandom : (pick < 8 ? 32'h0001_0000 : (pick == 8 ? '1 : '0));
            cfg_write(REG_SCALE, sc);
            pick = $urandom_range(9);
            mp = pick < 6 ? $urandom_range(255) : (pick < 8 ? $urandom : (pick == 8 ? '1 : '0));
            cfg_write(REG_MINP, mp);
            no_idle = ($urandom_range(7) == 0);
            repeat ($urandom_range(4, 10)) begin
                pick = $urandom_range(19);
                if (pick < 14) begin
                    len = (dims >= 1 && dims <= 18) ? dims : $urandom_range(1, 4);
                end else if (pick < 17) begin
                    len = $urandom_range(1, 5);
                end else if (pick < 18) begin
                    len = dims + 1;
                end else begin
                    len = 0;
                end
                if (len > 0) send_vector(len);
                if ($urandom_range(3) == 0)
                    send_item(MODE_COV, 4'($urandom), 4'($urandom), rand_cov(),
                              1'($urandom));
                if ($urandom_range(5) == 0)
                    send_item(MODE_MEAN, 4'($urandom), 4'($urandom),
                              $signed($urandom_range(131071)) - 32'sd65536, 1'($urandom));
                if ($urandom_range(9) == 0)
                    send_item(MODE_NONE, 4'($urandom), 4'($urandom), $urandom,
                              1'($urandom));
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_DIMS; i++) begin
            mean_mem[i] = 0;
            diff_mem[i] = 0;
        end
        for (int i = 0; i < MAX_DIMS*MAX_DIMS; i++) icov_mem[i] = 0;
        qf_acc = 0;
        elem_cnt = 0;
        dims_reg = 1;
        scale_reg = 65536;
        minp_reg = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_stores();
        test_directed();
        test_saturation();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatches == 0 && pending_densities.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
